// ===== hw/rtl/sgpg_pkg.sv =====
// Shared constants for the sky gradient pixel generator.
// Fixed-point format, size limits and the constant divisors used by the color stage.
// No dependencies.
package sgpg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_WIDTH = 4096;

    localparam int CFG_W  = 13;
    localparam int PIX_W  = 12;
    localparam int RGB_W  = 24;

    // Chain lengths and widths
    localparam int XY_NW  = 32;
    localparam int XDEN_W = 16;
    localparam int YDEN_W = 12;
    localparam int SQ_NW  = 36;
    localparam int SQ_STEPS = 18;
    localparam int YU_NW  = 33;
    localparam int L_W    = 18;
    localparam int FX_W   = FRAC_BITS + 1;

    localparam logic [CFG_W-1:0] RESET_WIDTH = 13'd1024;
    localparam logic [CFG_W-1:0] MIN_WIDTH   = 13'd4;
    localparam logic [CFG_W-1:0] WIDE_A      = 13'd800;
    localparam logic [CFG_W-1:0] WIDE_B      = 13'd1024;

    localparam logic [FX_W-1:0]  Q_ONE       = FX_W'(1) << FRAC_BITS;

    // 255.999 scaled by 1000
    localparam logic [17:0] COLOR_K = 18'd255999;
    // floor(2^32 / 125) and floor(2^32 / 625)
    localparam logic [25:0] RECIP_125 = 26'd34359738;
    localparam logic [22:0] RECIP_625 = 23'd6871947;
    localparam logic [15:0] DIV_125   = 16'd125;
    localparam logic [17:0] DIV_625   = 18'd625;

endpackage

// ===== hw/rtl/sgpg_div_cell.sv =====
// One restoring-division step: shifts in a numerator bit, produces one quotient bit.
// Standalone cell; chained by the top level. No package dependencies.
module sgpg_div_cell #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_rem,
    input  logic [NW-1:0] i_quo,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [NW-1:0] o_num,
    output logic [DW-1:0] o_rem,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [NW-1:0] n_num, n_quo;
    logic [DW-1:0] n_rem;
    logic [NW-1:0] r_num, r_quo;
    logic [DW-1:0] r_rem, r_den;
    logic [SW-1:0] r_side;

    always_comb begin
        trial = {i_rem, i_num[NW-1]};
        diff  = trial - {1'b0, i_den};
        ge    = (trial >= {1'b0, i_den});
        n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];
        n_quo = {i_quo[NW-2:0], ge};
        n_num = {i_num[NW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= i_den;
        r_side <= i_side;
    end

    assign o_num  = r_num;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_den  = r_den;
    assign o_side = r_side;
endmodule

// ===== hw/rtl/sgpg_sqrt_cell.sv =====
// One step of the bitwise integer square root, for a fixed bit position.
// Standalone cell; chained by the top level. No package dependencies.
module sgpg_sqrt_cell #(
    parameter int NW     = 36,
    parameter int BITPOS = 34,
    parameter int SW     = 1
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_n,
    input  logic [NW-1:0] i_root,
    input  logic [SW-1:0] i_side,
    output logic [NW-1:0] o_n,
    output logic [NW-1:0] o_root,
    output logic [SW-1:0] o_side
);
    localparam logic [NW-1:0] StepBit = NW'(1) << BITPOS;

    logic [NW-1:0] trial;
    logic          ge;
    logic [NW-1:0] n_n, n_root;
    logic [NW-1:0] r_n, r_root;
    logic [SW-1:0] r_side;

    always_comb begin
        trial  = i_root + StepBit;
        ge     = (i_n >= trial);
        n_n    = ge ? (i_n - trial) : i_n;
        n_root = ge ? ((i_root >> 1) + StepBit) : (i_root >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_root <= n_root;
        r_side <= i_side;
    end

    assign o_n    = r_n;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule

// ===== hw/rtl/sky_gradient_pixel_generator_top.sv =====
// Top level of the sky gradient pixel generator: setup stage, division, square root
// and color chains. Depends on sgpg_pkg, sgpg_div_cell and sgpg_sqrt_cell.
//
// Usage:
//   Input channel: raise start with i_pixel_column / i_screen_row; the transaction
//   is taken at a clock edge where start is high and busy is low. busy is low in
//   every cycle except the one after reset and the one after a configuration write,
//   so outside those cycles a new pixel can be taken every clock.
//   Result channel: o_result_valid strobes for one cycle with o_pixel_rgb and
//   o_outside_image. The receiver cannot stall; it must take each result then.
//   Configuration: i_cfg_valid / o_cfg_ready with i_cfg_data writes the screen
//   width register (o_cfg_ready is always high). Write only while no pixels are
//   in flight.
//   Throughput: one pixel per clock while busy is low. The pipeline is made of
//   the cell chains: 32 cells for the X/Y normalizing divides, 18 cells for the
//   square root, 33 cells for the unit-Y divide, plus seven single stages around
//   them.
//   Reset: the screen width returns to 1024, all in-flight transactions are dropped.
module sky_gradient_pixel_generator_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [sgpg_pkg::PIX_W-1:0] i_pixel_column,
    input  logic [sgpg_pkg::PIX_W-1:0] i_screen_row,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [sgpg_pkg::CFG_W-1:0] i_cfg_data,
    output logic                     o_result_valid,
    output logic [sgpg_pkg::RGB_W-1:0] o_pixel_rgb,
    output logic                     o_outside_image
);
    import sgpg_pkg::*;

    localparam int LAT = 1 + XY_NW + 2 + SQ_STEPS + YU_NW + 4;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_scr_width;
    logic             r_cfg_busy;
    logic             cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_width <= RESET_WIDTH;
            r_cfg_busy  <= 1'b1;
        end else begin
            if (cfg_acc) begin
                r_scr_width <= i_cfg_data;
            end
            // Hold off pixels for the cycle the derived geometry settles
            r_cfg_busy <= cfg_acc;
        end
    end

    assign busy = r_cfg_busy;

    // Derived geometry, refreshed every cycle from the width register
    logic [CFG_W-1:0]  w_clamp;
    logic              is_43;
    logic [15:0]       h_full;
    logic [CFG_W-1:0]  r_w;
    logic [PIX_W-1:0]  r_h, r_wm1, r_hm1;
    logic [XDEN_W-1:0] r_denx;
    logic              r_is43;

    always_comb begin
        priority if (r_scr_width < MIN_WIDTH) begin
            w_clamp = MIN_WIDTH;
        end else if (r_scr_width > CFG_W'(MAX_WIDTH)) begin
            w_clamp = CFG_W'(MAX_WIDTH);
        end else begin
            w_clamp = r_scr_width;
        end
        is_43  = (w_clamp == WIDE_A) || (w_clamp == WIDE_B);
        h_full = is_43 ? ((16'(w_clamp) * 16'd3) >> 2) : ((16'(w_clamp) * 16'd9) >> 4);
    end

    always_ff @(posedge i_clk) begin
        r_w    <= w_clamp;
        r_h    <= h_full[PIX_W-1:0];
        r_wm1  <= PIX_W'(w_clamp - 13'd1);
        r_hm1  <= PIX_W'(h_full - 16'd1);
        r_is43 <= is_43;
        r_denx <= XDEN_W'(w_clamp - 13'd1) * (is_43 ? XDEN_W'(3) : XDEN_W'(9));
    end

    // ---------------- valid line ----------------
    logic           in_acc;
    logic [LAT-1:0] r_vld;

    assign in_acc = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], in_acc};
        end
    end

    // ---------------- stage A: offsets from image center ----------------
    logic [12:0]      two_c, two_v, dx13, dy13;
    logic [PIX_W-1:0] vv;
    logic             a_neg, a_out;
    logic [15:0]      xa;
    logic [XY_NW-1:0] r_a_numx, r_a_numy;
    logic             r_a_out, r_a_neg;

    always_comb begin
        a_out = ({1'b0, i_pixel_column} >= r_w) || (i_screen_row >= r_h);
        two_c = {i_pixel_column, 1'b0};
        dx13  = (two_c >= 13'(r_wm1)) ? (two_c - 13'(r_wm1)) : (13'(r_wm1) - two_c);
        vv    = r_hm1 - i_screen_row;
        two_v = {vv, 1'b0};
        a_neg = (two_v < 13'(r_hm1));
        dy13  = a_neg ? (13'(r_hm1) - two_v) : (two_v - 13'(r_hm1));
        // Aspect numerator 4 or 16 is a shift
        xa    = r_is43 ? {2'b00, dx13[11:0], 2'b00} : {dx13[11:0], 4'b0000};
    end

    always_ff @(posedge i_clk) begin
        r_a_numx <= {xa, 16'b0};
        r_a_numy <= {4'b0, dy13[11:0], 16'b0};
        r_a_out  <= a_out;
        r_a_neg  <= a_neg;
    end

    // ---------------- X and Y divide chains ----------------
    logic [XY_NW-1:0]  xnum [0:XY_NW];
    logic [XY_NW-1:0]  xquo [0:XY_NW];
    logic [XDEN_W-1:0] xrem [0:XY_NW];
    logic [XDEN_W-1:0] xden [0:XY_NW];
    logic              xside[0:XY_NW];
    logic [XY_NW-1:0]  ynum [0:XY_NW];
    logic [XY_NW-1:0]  yquo [0:XY_NW];
    logic [YDEN_W-1:0] yrem [0:XY_NW];
    logic [YDEN_W-1:0] yden [0:XY_NW];
    logic              yside[0:XY_NW];

    assign xnum[0]  = r_a_numx;
    assign xquo[0]  = '0;
    assign xrem[0]  = '0;
    assign xden[0]  = r_denx;
    assign xside[0] = r_a_out;
    assign ynum[0]  = r_a_numy;
    assign yquo[0]  = '0;
    assign yrem[0]  = '0;
    assign yden[0]  = r_hm1;
    assign yside[0] = r_a_neg;

    for (genvar k = 0; k < XY_NW; k++) begin : g_xy
        sgpg_div_cell #(.NW(XY_NW), .DW(XDEN_W), .SW(1)) u_xcell (
            .i_clk (i_clk),
            .i_num (xnum[k]), .i_rem (xrem[k]), .i_quo (xquo[k]),
            .i_den (xden[k]), .i_side(xside[k]),
            .o_num (xnum[k+1]), .o_rem (xrem[k+1]), .o_quo (xquo[k+1]),
            .o_den (xden[k+1]), .o_side(xside[k+1])
        );
        sgpg_div_cell #(.NW(XY_NW), .DW(YDEN_W), .SW(1)) u_ycell (
            .i_clk (i_clk),
            .i_num (ynum[k]), .i_rem (yrem[k]), .i_quo (yquo[k]),
            .i_den (yden[k]), .i_side(yside[k]),
            .o_num (ynum[k+1]), .o_rem (yrem[k+1]), .o_quo (yquo[k+1]),
            .o_den (yden[k+1]), .o_side(yside[k+1])
        );
    end

    // ---------------- stages B, C: squares and sum ----------------
    logic [FX_W-1:0]   b_x, b_y;
    logic [2*FX_W-1:0] r_b_x2, r_b_y2;
    logic [FX_W-1:0]   r_b_y, r_c_y;
    logic              r_b_out, r_b_neg, r_c_out, r_c_neg;
    logic [SQ_NW-1:0]  r_c_sum;

    assign b_x = xquo[XY_NW][FX_W-1:0];
    assign b_y = yquo[XY_NW][FX_W-1:0];

    always_ff @(posedge i_clk) begin
        r_b_x2  <= b_x * b_x;
        r_b_y2  <= b_y * b_y;
        r_b_y   <= b_y;
        r_b_out <= xside[XY_NW];
        r_b_neg <= yside[XY_NW];
        r_c_sum <= SQ_NW'(r_b_x2) + SQ_NW'(r_b_y2) + (SQ_NW'(1) << (2 * FRAC_BITS));
        r_c_y   <= r_b_y;
        r_c_out <= r_b_out;
        r_c_neg <= r_b_neg;
    end

    // ---------------- square root chain ----------------
    localparam int SQ_SW = FX_W + 2;

    logic [SQ_NW-1:0] sq_n    [0:SQ_STEPS];
    logic [SQ_NW-1:0] sq_root [0:SQ_STEPS];
    logic [SQ_SW-1:0] sq_side [0:SQ_STEPS];

    assign sq_n[0]    = r_c_sum;
    assign sq_root[0] = '0;
    assign sq_side[0] = {r_c_out, r_c_neg, r_c_y};

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        sgpg_sqrt_cell #(.NW(SQ_NW), .BITPOS(2 * (SQ_STEPS - 1 - k)), .SW(SQ_SW)) u_cell (
            .i_clk (i_clk),
            .i_n   (sq_n[k]),   .i_root(sq_root[k]),   .i_side(sq_side[k]),
            .o_n   (sq_n[k+1]), .o_root(sq_root[k+1]), .o_side(sq_side[k+1])
        );
    end

    // ---------------- unit-Y divide chain ----------------
    logic [YU_NW-1:0] unum [0:YU_NW];
    logic [YU_NW-1:0] uquo [0:YU_NW];
    logic [L_W-1:0]   urem [0:YU_NW];
    logic [L_W-1:0]   uden [0:YU_NW];
    logic [1:0]       uside[0:YU_NW];

    assign unum[0]  = {sq_side[SQ_STEPS][FX_W-1:0], 16'b0};
    assign uquo[0]  = '0;
    assign urem[0]  = '0;
    assign uden[0]  = sq_root[SQ_STEPS][L_W-1:0];
    assign uside[0] = sq_side[SQ_STEPS][SQ_SW-1 -: 2];

    for (genvar k = 0; k < YU_NW; k++) begin : g_yu
        sgpg_div_cell #(.NW(YU_NW), .DW(L_W), .SW(2)) u_cell (
            .i_clk (i_clk),
            .i_num (unum[k]), .i_rem (urem[k]), .i_quo (uquo[k]),
            .i_den (uden[k]), .i_side(uside[k]),
            .o_num (unum[k+1]), .o_rem (urem[k+1]), .o_quo (uquo[k+1]),
            .o_den (uden[k+1]), .o_side(uside[k+1])
        );
    end

    // ---------------- stage D: blend factor t ----------------
    logic [FX_W-1:0] d_yu;
    logic [FX_W:0]   d_t;
    logic [FX_W-1:0] r_d_t;
    logic            r_d_out;

    always_comb begin
        d_yu = (uquo[YU_NW] > YU_NW'(Q_ONE)) ? Q_ONE : uquo[YU_NW][FX_W-1:0];
        d_t  = uside[YU_NW][0] ? ((FX_W + 1)'(Q_ONE - d_yu) >> 1)
                               : (((FX_W + 1)'(Q_ONE) + (FX_W + 1)'(d_yu)) >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_d_t   <= d_t[FX_W-1:0];
        r_d_out <= uside[YU_NW][1];
    end

    // ---------------- stage E: scale by 255.999 ----------------
    logic [17:0] e_rin;
    logic [19:0] e_gin;
    logic [35:0] r_e_ra;
    logic [37:0] r_e_ga;
    logic        r_e_out;

    always_comb begin
        e_rin = (18'(Q_ONE) << 1) - 18'(r_d_t);
        e_gin = 20'(Q_ONE) * 20'd10 - 20'(r_d_t) * 20'd3;
    end

    always_ff @(posedge i_clk) begin
        r_e_ra  <= 36'(COLOR_K) * 36'(e_rin);
        r_e_ga  <= 38'(COLOR_K) * 38'(e_gin);
        r_e_out <= r_d_out;
    end

    // ---------------- stage F: reciprocal estimate ----------------
    logic [15:0] f_rv;
    logic [17:0] f_gv;
    logic [41:0] f_rp;
    logic [40:0] f_gp;
    logic [15:0] r_f_rv;
    logic [17:0] r_f_gv;
    logic [9:0]  r_f_rq;
    logic [8:0]  r_f_gq;
    logic        r_f_out;

    always_comb begin
        // Power-of-two part of the divisor (2^20) is a shift
        f_rv = r_e_ra[35:20];
        f_gv = r_e_ga[37:20];
        f_rp = 42'(f_rv) * 42'(RECIP_125);
        f_gp = 41'(f_gv) * 41'(RECIP_625);
    end

    always_ff @(posedge i_clk) begin
        r_f_rv  <= f_rv;
        r_f_gv  <= f_gv;
        r_f_rq  <= f_rp[41:32];
        r_f_gq  <= f_gp[40:32];
        r_f_out <= r_e_out;
    end

    // ---------------- stage G: correct, clamp, pack ----------------
    logic [15:0] g_rr;
    logic [17:0] g_gr;
    logic [9:0]  g_rq;
    logic [9:0]  g_gq;
    logic [7:0]  g_red, g_green;
    logic [RGB_W-1:0] r_rgb;
    logic        r_out;

    always_comb begin
        g_rr    = r_f_rv - 16'(r_f_rq) * DIV_125;
        g_gr    = r_f_gv - 18'(r_f_gq) * DIV_625;
        // Estimate may fall one short: bump it when the remainder shows so
        g_rq    = (g_rr >= DIV_125) ? (r_f_rq + 10'd1) : r_f_rq;
        g_gq    = (g_gr >= DIV_625) ? (10'(r_f_gq) + 10'd1) : 10'(r_f_gq);
        g_red   = (g_rq > 10'd255) ? 8'hFF : g_rq[7:0];
        g_green = (g_gq > 10'd255) ? 8'hFF : g_gq[7:0];
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= r_f_out ? '0 : {g_red, g_green, 8'hFF};
        r_out <= r_f_out;
    end

    assign o_result_valid  = r_vld[LAT-1];
    assign o_pixel_rgb     = r_rgb;
    assign o_outside_image = r_out;

    // ---------------- assertions ----------------
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##(LAT) o_result_valid)
        else $error("result strobe missing after fixed latency");

    a_cfg_holdoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> busy)
        else $error("pixel accepted while geometry settles");

    a_outside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_outside_image) |-> (o_pixel_rgb == '0))
        else $error("outside pixel carries color");

    a_blue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_outside_image) |-> (o_pixel_rgb[7:0] == 8'hFF))
        else $error("blue channel not saturated");
endmodule
